/* src/srk_pkg.sv */
`default_nettype none
package srk_pkg;

   localparam int LIST_DEPTH = 8;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W     = 48;
   localparam int STR_W      = 8;
   localparam int AGE_W      = 32;
   localparam int AIR_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [AGE_W-1:0] STALE_RESET = AGE_W'(30000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ONLY_MATCHED   = 3'd0,
      CSR_MATCH_PRIORITY = 3'd1,
      CSR_STRENGTH_FLOOR = 3'd2,
      CSR_AGE_LIMIT      = 3'd3,
      CSR_STALE_LIMIT    = 3'd4,
      CSR_OUT_LIMIT      = 3'd5
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]       address;
      logic signed [STR_W-1:0] strength;
      logic                    matched;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic shift;
      logic match_priority;
   } cell_ctrl_type;

endpackage
`default_nettype wire

/* src/srk_cell.sv */
`default_nettype none
module srk_cell
   import srk_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire entry_type     new_entry,
   input  wire entry_type     prev_entry,
   input  wire entry_type     next_entry,
   input  wire logic          ins_prev,
   input  wire logic          beyond_fill,
   input  wire logic          in_limit,
   output entry_type          entry,
   output logic               ins_out
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      better;

   always_comb begin
      if (ctrl.match_priority && (new_entry.matched != entry_ff.matched)) begin
         better = new_entry.matched;
      end else begin
         better = new_entry.strength > entry_ff.strength;
      end
   end

   // insertion point is at or above this cell
   assign ins_out = ins_prev | beyond_fill | better;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = next_entry;
      end else if (ctrl.insert && in_limit && ins_out) begin
         entry_in = ins_prev ? prev_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

/* src/srk_chain.sv */
`default_nettype none
module srk_chain
   import srk_pkg::*;
(
   input  wire logic             clock,
   input  wire cell_ctrl_type    ctrl,
   input  wire entry_type        new_entry,
   input  wire logic [CNT_W-1:0] fill_eff,
   input  wire logic [CNT_W-1:0] limit,
   output entry_type             head,
   output logic                  inserted
);

   entry_type              entries [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]  ins;
   logic [LIST_DEPTH-1:0]  in_lim;

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      entry_type prev_e;
      entry_type next_e;
      logic      ins_p;

      assign in_lim[i] = CNT_W'(i) < limit;

      if (i == 0) begin : g_first
         assign prev_e = new_entry;
         assign ins_p  = 1'b0;
      end else begin : g_rest
         assign prev_e = entries[i-1];
         assign ins_p  = ins[i-1];
      end

      if (i == LIST_DEPTH - 1) begin : g_last
         assign next_e = '0;
      end else begin : g_inner
         assign next_e = entries[i+1];
      end

      srk_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .prev_entry  (prev_e),
         .next_entry  (next_e),
         .ins_prev    (ins_p),
         .beyond_fill (CNT_W'(i) >= fill_eff),
         .in_limit    (in_lim[i]),
         .entry       (entries[i]),
         .ins_out     (ins[i])
      );
   end

   assign head     = entries[0];
   assign inserted = |(ins & in_lim);

endmodule
`default_nettype wire

/* src/filtered_top_k_signal_ranker_unit.sv */
`default_nettype none
// Filtered top-K signal ranker.
// Requests: one device record per request, accepted at a rising edge with
// start high and busy low. Each record updates the on-air counters and, if it
// passes the filters, is inserted into the ranked list in the same cycle, so
// records that do not end a batch are taken one per cycle with busy low.
// A record with req_last_record set ends the batch: busy rises on the next
// cycle and the list is emitted from the head of the cell chain, one entry per
// cycle on rsp_valid, starting the cycle after acceptance. A batch of N kept
// entries holds busy until all N are emitted; an empty list gives one result
// with rsp_entry_valid low. rsp_last_result marks the final result, after
// which the list and counters are clear and the next request is taken.
// The emit rate is set by the chain shifting one cell toward the head per
// cycle. Results cannot be stalled: each is present for exactly one cycle.
// CSR writes land at the edge where csr_we is high; write only while idle.
// Reset (synchronous) empties the list, clears counters, and restores
// register defaults.
module filtered_top_k_signal_ranker_unit
   import srk_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [ADDR_W-1:0]       req_device_address,
   input  wire logic signed [STR_W-1:0] req_strength,
   input  wire logic                    req_is_matched,
   input  wire logic [AGE_W-1:0]        req_age_ms,
   input  wire logic                    req_last_record,
   output logic                         rsp_valid,
   output logic                         rsp_entry_valid,
   output logic [ADDR_W-1:0]            rsp_ranked_address,
   output logic signed [STR_W-1:0]      rsp_ranked_strength,
   output logic                         rsp_ranked_matched,
   output logic [CNT_W-1:0]             rsp_list_count,
   output logic [AIR_W-1:0]             rsp_on_air_count,
   output logic [AIR_W-1:0]             rsp_on_air_matched,
   output logic                         rsp_last_result,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   logic                    only_matched_ff;
   logic                    match_priority_ff;
   logic signed [STR_W-1:0] floor_ff;
   logic [AGE_W-1:0]        age_limit_ff;
   logic [AGE_W-1:0]        stale_limit_ff;
   logic [3:0]              out_limit_ff;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [AIR_W-1:0] air_ff, air_in;
   logic [AIR_W-1:0] air_m_ff, air_m_in;
   logic [AIR_W-1:0] snap_air_ff, snap_air_in;
   logic [AIR_W-1:0] snap_air_m_ff, snap_air_m_in;

   logic             accept;
   logic             emitting;
   logic [CNT_W-1:0] limit;
   logic [CNT_W-1:0] fill_eff;
   logic [CNT_W-1:0] fill_next;
   logic             pass;
   logic             on_air;
   logic             inserted;
   logic [AIR_W-1:0] air_upd;
   logic [AIR_W-1:0] air_m_upd;
   entry_type        new_entry;
   entry_type        head;
   cell_ctrl_type    ctrl;

   assign accept = start && !busy;

   // effective list limit: clamp out_limit into 1..LIST_DEPTH
   always_comb begin
      if (out_limit_ff == 4'd0) begin
         limit = CNT_W'(1);
      end else if (32'(out_limit_ff) > LIST_DEPTH) begin
         limit = CNT_W'(LIST_DEPTH);
      end else begin
         limit = CNT_W'(out_limit_ff);
      end
   end

   assign fill_eff = (fill_ff > limit) ? limit : fill_ff;

   always_comb begin
      pass = 1'b1;
      if (only_matched_ff && !req_is_matched) pass = 1'b0;
      if (req_strength < floor_ff) pass = 1'b0;
      if ((age_limit_ff != '0) && (req_age_ms > age_limit_ff)) pass = 1'b0;
   end

   assign on_air = req_age_ms <= stale_limit_ff;

   // saturate both counters at all ones
   assign air_upd   = (on_air && (air_ff != '1)) ? air_ff + AIR_W'(1) : air_ff;
   assign air_m_upd = (on_air && req_is_matched && (air_m_ff != '1)) ?
                      air_m_ff + AIR_W'(1) : air_m_ff;

   assign fill_next = (pass && inserted && (fill_eff < limit)) ?
                      fill_eff + CNT_W'(1) : fill_eff;

   assign new_entry.address  = req_device_address;
   assign new_entry.strength = req_strength;
   assign new_entry.matched  = req_is_matched;

   assign ctrl.insert         = accept && pass;
   assign ctrl.shift          = emitting;
   assign ctrl.match_priority = match_priority_ff;

   srk_chain u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .new_entry (new_entry),
      .fill_eff  (fill_eff),
      .limit     (limit),
      .head      (head),
      .inserted  (inserted)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_record) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (remain_ff == CNT_W'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            emitting = 1'b0;
         end
         ST_EMIT: begin
            busy     = 1'b1;
            emitting = 1'b1;
         end
         default: begin
            busy     = 1'b0;
            emitting = 1'b0;
         end
      endcase
   end

   always_comb begin
      fill_in       = fill_ff;
      remain_in     = remain_ff;
      count_in      = count_ff;
      air_in        = air_ff;
      air_m_in      = air_m_ff;
      snap_air_in   = snap_air_ff;
      snap_air_m_in = snap_air_m_ff;
      if (accept) begin
         fill_in  = fill_next;
         air_in   = air_upd;
         air_m_in = air_m_upd;
         if (req_last_record) begin
            count_in      = fill_next;
            remain_in     = (fill_next == '0) ? CNT_W'(1) : fill_next;
            snap_air_in   = air_upd;
            snap_air_m_in = air_m_upd;
            air_in        = '0;
            air_m_in      = '0;
         end
      end else if (emitting) begin
         remain_in = remain_ff - CNT_W'(1);
         if (remain_ff == CNT_W'(1)) fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         remain_ff <= '0;
         air_ff    <= '0;
         air_m_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         remain_ff <= remain_in;
         air_ff    <= air_in;
         air_m_ff  <= air_m_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      snap_air_ff   <= snap_air_in;
      snap_air_m_ff <= snap_air_m_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         only_matched_ff   <= 1'b0;
         match_priority_ff <= 1'b0;
         floor_ff          <= STR_W'(-128);
         age_limit_ff      <= '0;
         stale_limit_ff    <= STALE_RESET;
         out_limit_ff      <= 4'd8;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ONLY_MATCHED:   only_matched_ff   <= csr_data[0];
            CSR_MATCH_PRIORITY: match_priority_ff <= csr_data[0];
            CSR_STRENGTH_FLOOR: floor_ff          <= csr_data[STR_W-1:0];
            CSR_AGE_LIMIT:      age_limit_ff      <= csr_data[AGE_W-1:0];
            CSR_STALE_LIMIT:    stale_limit_ff    <= csr_data[AGE_W-1:0];
            CSR_OUT_LIMIT:      out_limit_ff      <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid           = emitting;
   assign rsp_entry_valid     = count_ff != '0;
   assign rsp_ranked_address  = rsp_entry_valid ? head.address : '0;
   assign rsp_ranked_strength = rsp_entry_valid ? head.strength : '0;
   assign rsp_ranked_matched  = rsp_entry_valid && head.matched;
   assign rsp_list_count      = count_ff;
   assign rsp_on_air_count    = snap_air_ff;
   assign rsp_on_air_matched  = snap_air_m_ff;
   assign rsp_last_result     = emitting && (remain_ff == CNT_W'(1));

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_last_result |=> !rsp_valid)
      else $error("result after final result of burst");

   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_result) |=> rsp_valid)
      else $error("gap inside result burst");

   a_plain_record_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_last_record) |=> !rsp_valid)
      else $error("result after non-final record");

   a_last_record_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_record) |=> rsp_valid)
      else $error("final record did not start emission");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_list_count) <= LIST_DEPTH))
      else $error("list count beyond depth");

endmodule
`default_nettype wire

/* tb/sv/filtered_top_k_signal_ranker_unit_tb.sv */
`timescale 1ns / 1ps
module filtered_top_k_signal_ranker_unit_tb
   import srk_pkg::*;
();

   localparam int WATCHDOG_LIMIT     = 1000;
   localparam int SETTLE_CYCLES      = 4;
   localparam int SETTINGS_PER_PHASE = 4;
   localparam int ITEMS_PER_SETTING  = 30;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam logic signed [STR_W-1:0] STR_MIN = STR_W'(-128);
   localparam logic signed [STR_W-1:0] STR_MAX = STR_W'(127);

   typedef struct packed {
      logic [ADDR_W-1:0]       address;
      logic signed [STR_W-1:0] strength;
      logic                    matched;
      logic [AGE_W-1:0]        age_ms;
      logic                    last;
   } device_record_type;

   typedef struct packed {
      logic                    entry_valid;
      logic [ADDR_W-1:0]       address;
      logic signed [STR_W-1:0] strength;
      logic                    matched;
      logic [CNT_W-1:0]        list_count;
      logic [AIR_W-1:0]        on_air;
      logic [AIR_W-1:0]        on_air_matched;
      logic                    last;
   } ranked_entry_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [ADDR_W-1:0]       req_device_address = '0;
   logic signed [STR_W-1:0] req_strength = '0;
   logic                    req_is_matched = 1'b0;
   logic [AGE_W-1:0]        req_age_ms = '0;
   logic                    req_last_record = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_entry_valid;
   logic [ADDR_W-1:0]       rsp_ranked_address;
   logic signed [STR_W-1:0] rsp_ranked_strength;
   logic                    rsp_ranked_matched;
   logic [CNT_W-1:0]        rsp_list_count;
   logic [AIR_W-1:0]        rsp_on_air_count;
   logic [AIR_W-1:0]        rsp_on_air_matched;
   logic                    rsp_last_result;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   // shadow registers
   logic                    cfg_only_matched = 1'b0;
   logic                    cfg_match_priority = 1'b0;
   logic signed [STR_W-1:0] cfg_strength_floor = STR_W'(-128);
   logic [AGE_W-1:0]        cfg_age_limit = '0;
   logic [AGE_W-1:0]        cfg_stale_limit = STALE_RESET;
   logic [3:0]              cfg_out_limit = 4'd8;

   // predicted ranking state
   logic [ADDR_W-1:0]       rank_address [LIST_DEPTH];
   logic signed [STR_W-1:0] rank_strength [LIST_DEPTH];
   logic                    rank_matched [LIST_DEPTH];
   int unsigned             rank_fill = 0;
   logic [AIR_W-1:0]        air_total = '0;
   logic [AIR_W-1:0]        air_matched_total = '0;

   ranked_entry_type        expected_entries [$];
   ranked_entry_type        next_expected;
   int unsigned             error_count = 0;
   int unsigned             send_idle_pct = 11;
   int unsigned             stall_cycles = 0;

   filtered_top_k_signal_ranker_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_device_address  (req_device_address),
      .req_strength        (req_strength),
      .req_is_matched      (req_is_matched),
      .req_age_ms          (req_age_ms),
      .req_last_record     (req_last_record),
      .rsp_valid           (rsp_valid),
      .rsp_entry_valid     (rsp_entry_valid),
      .rsp_ranked_address  (rsp_ranked_address),
      .rsp_ranked_strength (rsp_ranked_strength),
      .rsp_ranked_matched  (rsp_ranked_matched),
      .rsp_list_count      (rsp_list_count),
      .rsp_on_air_count    (rsp_on_air_count),
      .rsp_on_air_matched  (rsp_on_air_matched),
      .rsp_last_result     (rsp_last_result),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #2 clock = ~clock;

   // Update counters, insert the record if it passes, emit the list on the last one.
   function automatic void rank_record(input device_record_type rec);
      int unsigned      lim;
      int unsigned      pos;
      int unsigned      k;
      logic             keep;
      ranked_entry_type entry;
      lim = (cfg_out_limit == 0) ? 1 :
            (cfg_out_limit > LIST_DEPTH) ? LIST_DEPTH : cfg_out_limit;
      // drop entries beyond a lowered limit
      if (rank_fill > lim) rank_fill = lim;
      if (rec.age_ms <= cfg_stale_limit) begin
         if (air_total != '1) air_total++;
         if (rec.matched && air_matched_total != '1) air_matched_total++;
      end
      keep = !(cfg_only_matched && !rec.matched) && !(rec.strength < cfg_strength_floor) &&
             !(cfg_age_limit != 0 && rec.age_ms > cfg_age_limit);
      if (keep) begin
         pos = 0;
         while (pos < rank_fill &&
                !((cfg_match_priority && rec.matched != rank_matched[pos]) ?
                  rec.matched : (rec.strength > rank_strength[pos])))
            pos++;
         if (pos < lim) begin
            k = (rank_fill < lim) ? rank_fill : lim - 1;
            for (; k > pos; k--) begin
               rank_address[k]  = rank_address[k-1];
               rank_strength[k] = rank_strength[k-1];
               rank_matched[k]  = rank_matched[k-1];
            end
            rank_address[pos]  = rec.address;
            rank_strength[pos] = rec.strength;
            rank_matched[pos]  = rec.matched;
            if (rank_fill < lim) rank_fill++;
         end
      end
      if (!rec.last) return;
      entry = '0;
      entry.on_air         = air_total;
      entry.on_air_matched = air_matched_total;
      if (rank_fill == 0) begin
         entry.last = 1'b1;
         expected_entries.push_back(entry);
      end else begin
         for (int i = 0; i < rank_fill; i++) begin
            entry.entry_valid = 1'b1;
            entry.address     = rank_address[i];
            entry.strength    = rank_strength[i];
            entry.matched     = rank_matched[i];
            entry.list_count  = CNT_W'(rank_fill);
            entry.last        = (i == rank_fill - 1);
            expected_entries.push_back(entry);
         end
      end
      rank_fill         = 0;
      air_total         = '0;
      air_matched_total = '0;
   endfunction

   function automatic void compare_field(input string field, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", field, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_entries.size() == 0) begin
            $error("result with nothing expected: address %0h", rsp_ranked_address);
            error_count++;
         end else begin
            next_expected = expected_entries.pop_front();
            compare_field("entry_valid", next_expected.entry_valid, rsp_entry_valid);
            compare_field("ranked_address", next_expected.address, rsp_ranked_address);
            compare_field("ranked_strength", next_expected.strength, rsp_ranked_strength);
            compare_field("ranked_matched", next_expected.matched, rsp_ranked_matched);
            compare_field("list_count", next_expected.list_count, rsp_list_count);
            compare_field("on_air_count", next_expected.on_air, rsp_on_air_count);
            compare_field("on_air_matched", next_expected.on_air_matched,
                          rsp_on_air_matched);
            compare_field("last_result", next_expected.last, rsp_last_result);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || csr_we) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance with start held.
   task automatic send_record(input logic [ADDR_W-1:0] address,
                              input logic signed [STR_W-1:0] strength,
                              input logic matched, input logic [AGE_W-1:0] age_ms,
                              input logic last);
      device_record_type rec;
      rec.address  = address;
      rec.strength = strength;
      rec.matched  = matched;
      rec.age_ms   = age_ms;
      rec.last     = last;
      while ($urandom_range(1, 100) <= send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start              <= 1'b1;
      req_device_address <= rec.address;
      req_strength       <= rec.strength;
      req_is_matched     <= rec.matched;
      req_age_ms         <= rec.age_ms;
      req_last_record    <= rec.last;
      do @(posedge clock); while (busy !== 1'b0);
      rank_record(rec);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      case (index)
         CSR_ONLY_MATCHED:   cfg_only_matched   = data[0];
         CSR_MATCH_PRIORITY: cfg_match_priority = data[0];
         CSR_STRENGTH_FLOOR: cfg_strength_floor = data[STR_W-1:0];
         CSR_AGE_LIMIT:      cfg_age_limit      = data[AGE_W-1:0];
         CSR_STALE_LIMIT:    cfg_stale_limit    = data[AGE_W-1:0];
         CSR_OUT_LIMIT:      cfg_out_limit      = data[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Drop start, drain the pending results, then let the block go quiet.
   task automatic settle_idle();
      start <= 1'b0;
      while (expected_entries.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic test_field_extremes();
      send_record('0, STR_MIN, 1'b0, '0, 1'b0);
      send_record('1, STR_MAX, 1'b1, STALE_RESET, 1'b0);
      send_record(48'h5555_5555_5555, STR_W'(0), 1'b1, STALE_RESET + 1, 1'b0);
      // equal strength to the second record: must stay behind it
      send_record(48'hAAAA_AAAA_AAAA, STR_MAX, 1'b0, '1, 1'b0);
      send_record(48'h0123_4567_89AB, STR_W'(-1), 1'b1, 32'h8000_0000, 1'b1);
   endtask

   task automatic test_tie_and_overflow();
      settle_idle();
      write_csr(CSR_OUT_LIMIT, 32'd15);
      for (int i = 0; i < LIST_DEPTH; i++)
         send_record(ADDR_W'(i + 1), STR_W'(-40), 1'($urandom), '0, 1'b0);
      // weaker than a full list: never inserted
      send_record(48'h00EE_0000_0001, STR_W'(-41), 1'b1, '0, 1'b0);
      // stronger: pushes the tail out
      send_record(48'h00EE_0000_0002, STR_W'(-39), 1'b0, '0, 1'b1);
   endtask

   task automatic test_filters();
      settle_idle();
      write_csr(CSR_ONLY_MATCHED, 32'd1);
      write_csr(CSR_STRENGTH_FLOOR, 32'd0);
      write_csr(CSR_AGE_LIMIT, 32'd1000);
      write_csr(CSR_STALE_LIMIT, 32'd0);
      send_record(48'h0000_0000_00A1, STR_W'(50), 1'b0, '0, 1'b0);
      send_record(48'h0000_0000_00A2, STR_W'(-1), 1'b1, '0, 1'b0);
      send_record(48'h0000_0000_00A3, STR_W'(10), 1'b1, 32'd1001, 1'b0);
      send_record(48'h0000_0000_00A4, STR_W'(0), 1'b1, 32'd1000, 1'b0);
      send_record(48'h0000_0000_00A5, STR_MAX, 1'b0, 32'd5, 1'b1);
      // batch that keeps nothing
      send_record(48'h0000_0000_00A6, STR_MIN, 1'b1, '0, 1'b1);
   endtask

   task automatic test_match_priority();
      settle_idle();
      write_csr(CSR_ONLY_MATCHED, 32'd0);
      write_csr(CSR_STRENGTH_FLOOR, 32'hFFFF_FF80);
      write_csr(CSR_AGE_LIMIT, '1);
      write_csr(CSR_STALE_LIMIT, '1);
      write_csr(CSR_MATCH_PRIORITY, 32'd1);
      write_csr(CSR_OUT_LIMIT, 32'd3);
      send_record(48'h0000_0000_00B1, STR_W'(100), 1'b0, '1, 1'b0);
      send_record(48'h0000_0000_00B2, STR_W'(-100), 1'b1, 32'd7, 1'b0);
      send_record(48'h0000_0000_00B3, STR_W'(50), 1'b0, 32'd7, 1'b0);
      send_record(48'h0000_0000_00B4, STR_W'(-100), 1'b1, 32'd7, 1'b0);
      send_record(48'h0000_0000_00B5, STR_MAX, 1'b0, 32'd7, 1'b1);
   endtask

   task automatic test_out_limit();
      settle_idle();
      write_csr(CSR_MATCH_PRIORITY, 32'd0);
      write_csr(CSR_AGE_LIMIT, 32'd0);
      write_csr(CSR_STALE_LIMIT, STALE_RESET);
      write_csr(CSR_OUT_LIMIT, 32'd0);
      send_record(48'h0000_0000_00C1, STR_W'(-20), 1'b0, '0, 1'b0);
      send_record(48'h0000_0000_00C2, STR_W'(-10), 1'b1, '0, 1'b1);
      settle_idle();
      write_csr(CSR_OUT_LIMIT, 32'd8);
      for (int i = 0; i < 4; i++)
         send_record(ADDR_W'(32'hC100 + i), 8'(-30 + 5 * i), 1'b0, 32'd100, 1'b0);
      // lower the limit in the middle of a batch; spare indexes must not land
      settle_idle();
      write_csr(CSR_OUT_LIMIT, 32'd2);
      write_csr(CSR_SPARE_6, '1);
      write_csr(CSR_SPARE_7, '1);
      send_record(48'h0000_0000_C1FF, STR_W'(-100), 1'b1, 32'd100, 1'b1);
   endtask

   task automatic test_random_batches();
      int unsigned             sent;
      int unsigned             batch_len;
      logic [AGE_W-1:0]        age;
      logic signed [STR_W-1:0] str;
      logic signed [STR_W-1:0] floor_val;
      logic [AGE_W-1:0]        limit_val;
      for (int phase = 0; phase < 3; phase++) begin
         for (int setting = 0; setting < SETTINGS_PER_PHASE; setting++) begin
            settle_idle();
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 49 : 0;
            write_csr(CSR_ONLY_MATCHED, {31'($urandom), 1'($urandom_range(0, 3) == 0)});
            write_csr(CSR_MATCH_PRIORITY, {31'($urandom), 1'($urandom)});
            case ($urandom_range(0, 3))
               0:       floor_val = STR_MIN;
               1:       floor_val = STR_W'($urandom);
               default: floor_val = STR_W'(-$urandom_range(20, 100));
            endcase
            write_csr(CSR_STRENGTH_FLOOR, {24'($urandom), floor_val});
            case ($urandom_range(0, 3))
               0:       limit_val = '0;
               1:       limit_val = '1;
               default: limit_val = $urandom_range(100, 40000);
            endcase
            write_csr(CSR_AGE_LIMIT, limit_val);
            case ($urandom_range(0, 4))
               0:       limit_val = STALE_RESET;
               1:       limit_val = '1;
               2:       limit_val = '0;
               default: limit_val = $urandom_range(100, 40000);
            endcase
            write_csr(CSR_STALE_LIMIT, limit_val);
            write_csr(CSR_OUT_LIMIT, {28'($urandom), 4'($urandom_range(0, 15))});
            sent = 0;
            while (sent < ITEMS_PER_SETTING) begin
               batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12);
               for (int i = 0; i < batch_len; i++) begin
                  case ($urandom_range(0, 5))
                     0:       age = $urandom;
                     1:       age = cfg_age_limit + $urandom_range(0, 2) - 1;
                     2:       age = cfg_stale_limit + $urandom_range(0, 2) - 1;
                     default: age = $urandom_range(0, 40000);
                  endcase
                  // cluster around the floor for boundary hits and ties
                  str = ($urandom_range(0, 3) == 0) ?
                        STR_W'(cfg_strength_floor + $urandom_range(0, 2) - 1) :
                        STR_W'($urandom);
                  send_record(ADDR_W'({$urandom, $urandom}), str, 1'($urandom), age,
                              i == batch_len - 1);
                  sent++;
               end
            end
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_field_extremes();
      test_tie_and_overflow();
      test_filters();
      test_match_priority();
      test_out_limit();
      test_random_batches();
      settle_idle();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* sim.f */
src/srk_pkg.sv
src/srk_cell.sv
src/srk_chain.sv
src/filtered_top_k_signal_ranker_unit.sv
tb/sv/filtered_top_k_signal_ranker_unit_tb.sv
